### hw/rtl/alp_pkg.sv
// Shared types and constants for the ASCII integer literal parser.
package alp_pkg;

    localparam int unsigned ValueW  = 64;
    localparam int unsigned StatusW = 2;
    localparam int unsigned CharW   = 8;

    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_FORMAT = 2'd1;
    localparam logic [StatusW-1:0] ST_OVER   = 2'd2;

    localparam logic [CharW-1:0] CH_SPACE = 8'h20;
    localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_NINE  = 8'h39;
    localparam logic [CharW-1:0] CH_A     = 8'h61;
    localparam logic [CharW-1:0] CH_F     = 8'h66;
    localparam logic [CharW-1:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [CharW-1:0] character;
        logic             last_char;
    } t_in_item;

    typedef struct packed {
        logic [ValueW-1:0]  value;
        logic [StatusW-1:0] status;
    } t_out_item;

    // Parse result handed to the finishing stage.
    typedef struct packed {
        logic [ValueW-1:0]  acc;
        logic               neg;
        logic [StatusW-1:0] status;
    } t_fin;

endpackage

### hw/rtl/ascii_integer_literal_parser.sv
// ASCII decimal/hex integer literal parser, top level.
// Throughput: one character per cycle while o_in_stall is low.
// The result of a last character moves from the input register to the finish register
// and then to the output register; a stall downstream can hold it in either register.
// Reset: synchronous active low; clears all valids and the parse state.
module ascii_integer_literal_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  alp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output alp_pkg::t_out_item o_out_item
);
    import alp_pkg::*;

    logic fin_valid;
    logic fin_stall;
    t_fin fin;

    alp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_fin_valid (fin_valid),
        .i_fin_stall (fin_stall),
        .o_fin       (fin)
    );

    alp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_fin_stall (fin_stall),
        .i_fin       (fin),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.value == '0)
        else $error("nonzero value with error status");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> fin_valid && fin_stall)
        else $error("input stalled without a waiting last item");
`endif

endmodule

### hw/rtl/alp_parse.sv
// Input register and per-character parse state update.
module alp_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  alp_pkg::t_in_item i_in_item,
    output logic            o_fin_valid,
    input  logic            i_fin_stall,
    output alp_pkg::t_fin   o_fin
);
    import alp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD, PH_ZERO, PH_SIGN, PH_DEC, PH_HEX0, PH_HEX, PH_TRAIL
    } t_phase;

    logic               r_in_valid;
    t_in_item           r_in;
    t_phase             r_phase, n_phase;
    logic [ValueW-1:0]  r_acc, n_acc;
    logic               r_neg, n_neg;
    logic [StatusW-1:0] r_err, n_err;

    logic [CharW-1:0]   ch;
    logic               is_dec, is_hexl, do_dec, do_hex, bad;
    logic [3:0]         dig;
    logic [ValueW+3:0]  dec_sum;
    logic               proc;
    logic [StatusW-1:0] fin_status;

    assign ch      = r_in.character;
    assign is_dec  = ch inside {[CH_ZERO:CH_NINE]};
    assign is_hexl = ch inside {[CH_A:CH_F]};
    assign dig     = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
    assign dec_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {{ValueW{1'b0}}, dig};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_err   = r_err;
        do_dec  = 1'b0;
        do_hex  = 1'b0;
        bad     = 1'b0;
        if (r_err == ST_OK) begin
            case (r_phase)
                PH_LEAD: begin
                    if (ch == CH_SPACE) begin
                    end else if (ch == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else if (ch == CH_MINUS) begin
                        n_phase = PH_SIGN;
                        n_neg   = 1'b1;
                    end else if (is_dec) begin
                        n_phase = PH_DEC;
                        do_dec  = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (ch == CH_X) begin
                        n_phase = PH_HEX0;
                    end else if (is_dec) begin
                        n_phase = PH_DEC;
                        do_dec  = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (ch == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else if (is_dec) begin
                        n_phase = PH_DEC;
                        do_dec  = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (is_dec) begin
                        do_dec = 1'b1;
                    end else if (ch == CH_SPACE) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_HEX0, PH_HEX: begin
                    if (is_dec || is_hexl) begin
                        n_phase = PH_HEX;
                        do_hex  = 1'b1;
                    end else if (r_phase == PH_HEX && ch == CH_SPACE) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (ch != CH_SPACE) begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
        end
        if (bad) begin
            n_err = ST_FORMAT;
        end else if (do_dec) begin
            if (|dec_sum[ValueW+3:ValueW]) begin
                n_err = ST_OVER;
            end else begin
                n_acc = dec_sum[ValueW-1:0];
            end
        end else if (do_hex) begin
            if (|r_acc[ValueW-1:ValueW-4]) begin
                n_err = ST_OVER;
            end else begin
                n_acc = {r_acc[ValueW-5:0], dig};
            end
        end
    end

    always_comb begin
        fin_status = n_err;
        if (n_err == ST_OK && (n_phase == PH_SIGN || n_phase == PH_HEX0)) begin
            fin_status = ST_FORMAT;
        end
    end

    assign o_fin_valid = r_in_valid && r_in.last_char;
    assign o_fin       = '{acc: n_acc, neg: n_neg, status: fin_status};
    assign proc        = r_in_valid && (!r_in.last_char || !i_fin_stall);
    assign o_in_stall  = r_in_valid && !proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_LEAD;
            r_acc      <= '0;
            r_neg      <= 1'b0;
            r_err      <= ST_OK;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                if (r_in.last_char) begin
                    r_phase <= PH_LEAD;
                    r_acc   <= '0;
                    r_neg   <= 1'b0;
                    r_err   <= ST_OK;
                end else begin
                    r_phase <= n_phase;
                    r_acc   <= n_acc;
                    r_neg   <= n_neg;
                    r_err   <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

endmodule

### hw/rtl/alp_emit.sv
// Finishing stage: finish register, sign handling, negative overflow check and output register.
module alp_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fin_valid,
    output logic               o_fin_stall,
    input  alp_pkg::t_fin      i_fin,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output alp_pkg::t_out_item o_out_item
);
    import alp_pkg::*;

    logic      r_fin_valid;
    t_fin      r_fin;
    logic      r_out_valid;
    t_out_item r_out, n_out;
    logic      out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_fin_stall = r_fin_valid && !out_free;

    always_comb begin
        n_out.value  = '0;
        n_out.status = r_fin.status;
        if (r_fin.status == ST_OK) begin
            if (r_fin.neg) begin
                if (r_fin.acc[ValueW-1]) begin
                    n_out.status = ST_OVER;
                end else begin
                    n_out.value = '0 - r_fin.acc;
                end
            end else begin
                n_out.value = r_fin.acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_fin_stall) begin
                r_fin_valid <= i_fin_valid;
            end
            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid && !o_fin_stall) begin
            r_fin <= i_fin;
        end
        if (r_fin_valid && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
